/* rtl/oqn_pkg.sv */
// ----------------------------------------------------------------------------
// oqn_pkg: shared types for the orientation quaternion normalizer
// Holds the per-sample component record that travels down the cell chains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package oqn_pkg;

  localparam int unsigned CompWidth  = 15;  // magnitude of a decoded word
  localparam int unsigned SumWidth   = 32;  // exact sum of four squares
  localparam int unsigned RootWidth  = 16;  // integer square root of the sum
  localparam int unsigned RemWidth   = 18;  // partial remainder in both chains
  localparam int unsigned NumLanes   = 4;

  // Component magnitudes, output sign flags (z already inverted) and the
  // zero-magnitude flag.
  typedef struct packed {
    logic [NumLanes-1:0][CompWidth-1:0] abs_v;
    logic [NumLanes-1:0]                neg;
    logic                               zero;
  } comp_t;

endpackage

/* rtl/oqn_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// oqn_sqrt_cell: one root bit of the integer square root
// Takes two radicand bits, settles one root bit and passes the rest on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module oqn_sqrt_cell
  import oqn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [SumWidth-1:0]  rad_i,
  input  logic [RootWidth-1:0] root_i,
  input  logic [RemWidth-1:0]  rem_i,
  input  comp_t                comp_i,
  output logic                 valid_o,
  output logic [SumWidth-1:0]  rad_o,
  output logic [RootWidth-1:0] root_o,
  output logic [RemWidth-1:0]  rem_o,
  output comp_t                comp_o
);

  logic [RemWidth+1:0] trial_rem;
  logic [RemWidth+1:0] trial_sub;
  logic [RootWidth-1:0] root_d;
  logic [RemWidth-1:0]  rem_d;

  always_comb begin
    trial_rem = {rem_i, rad_i[SumWidth-1 -: 2]};
    trial_sub = {2'b00, root_i, 2'b01};
    if (trial_rem >= trial_sub) begin
      rem_d  = RemWidth'(trial_rem - trial_sub);
      root_d = {root_i[RootWidth-2:0], 1'b1};
    end else begin
      rem_d  = RemWidth'(trial_rem);
      root_d = {root_i[RootWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[SumWidth-3:0], 2'b00};
      root_o <= root_d;
      rem_o  <= rem_d;
      comp_o <= comp_i;
    end
  end

endmodule

/* rtl/oqn_div_cell.sv */
// ----------------------------------------------------------------------------
// oqn_div_cell: one quotient bit for all four component dividers
// Restoring division step, shared divisor, four lanes side by side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module oqn_div_cell
  import oqn_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [RootWidth:0]                   div_i,
  input  logic [NumLanes-1:0][RemWidth-1:0]    rem_i,
  input  logic [NumLanes-1:0][FRAC_BITS:0]     dsh_i,
  input  logic [NumLanes-1:0][FRAC_BITS:0]     quo_i,
  input  comp_t                                comp_i,
  output logic                                 valid_o,
  output logic [RootWidth:0]                   div_o,
  output logic [NumLanes-1:0][RemWidth-1:0]    rem_o,
  output logic [NumLanes-1:0][FRAC_BITS:0]     dsh_o,
  output logic [NumLanes-1:0][FRAC_BITS:0]     quo_o,
  output comp_t                                comp_o
);

  logic [NumLanes-1:0][RemWidth-1:0] rem_d;
  logic [NumLanes-1:0][FRAC_BITS:0]  quo_d;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      logic [RemWidth-1:0] shifted;
      shifted = {rem_i[l][RemWidth-2:0], dsh_i[l][FRAC_BITS]};
      if (shifted >= {1'b0, div_i}) begin
        rem_d[l] = shifted - {1'b0, div_i};
        quo_d[l] = {quo_i[l][FRAC_BITS-1:0], 1'b1};
      end else begin
        rem_d[l] = shifted;
        quo_d[l] = {quo_i[l][FRAC_BITS-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o  <= div_i;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      comp_o <= comp_i;
      for (int l = 0; l < NumLanes; l++) begin
        dsh_o[l] <= {dsh_i[l][FRAC_BITS-1:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/orientation_quaternion_normalizer.sv */
// ----------------------------------------------------------------------------
// orientation_quaternion_normalizer: raw orientation words to unit quaternion
// Decodes four sign-coded words, normalizes by the integer magnitude.
// ----------------------------------------------------------------------------
// A new sample beat is taken every clock cycle unless the chain holds; each
// sample goes through the decode, square and sum stages, a chain of 16
// square-root cells, the divider setup stage, FRAC_BITS + 1 divider cells,
// then the output stage. The whole chain advances together; a two-entry
// output buffer (output register plus skid register) lets the input keep
// flowing while one result waits at the output, and the chain only holds
// when both entries are full. Outputs are Q1.FRAC_BITS, rounded to
// nearest with ties away from zero and saturated to +-(2^FRAC_BITS - 1);
// the z component comes out negated. An all-zero sample gives zero
// components with the zero_magnitude flag set on tuser.
`timescale 1ns / 1ps
module orientation_quaternion_normalizer
  import oqn_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // raw_w, raw_x, raw_y, raw_z (16 bits each)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic        m_axis_tuser    // zero_magnitude
);

  localparam int unsigned DivCells = FRAC_BITS + 1;
  localparam int unsigned DivWidth = FRAC_BITS + 17;  // 2*a*2^F + M
  localparam logic [FRAC_BITS:0] SatMax = {1'b0, {FRAC_BITS{1'b1}}};

  // The chain advances whenever the skid register is free.
  logic en;
  logic skid_valid_q;
  assign en            = ~skid_valid_q;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- decode
  comp_t dec_d, dec_q;
  logic  dec_valid_q;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      logic [15:0] raw;
      logic [15:0] neg_raw;
      raw     = s_axis_tdata[16*l +: 16];
      neg_raw = 16'd0 - raw;
      if (!raw[15]) begin
        dec_d.abs_v[l] = raw[14:0];
      end else if (raw == 16'h8000) begin
        dec_d.abs_v[l] = 15'h7FFF;
      end else begin
        dec_d.abs_v[l] = neg_raw[14:0];
      end
      dec_d.neg[l] = raw[15];
    end
    // The z result is negated, so its sign flag is inverted here.
    dec_d.neg[3] = ~s_axis_tdata[63];
    dec_d.zero   = 1'b0;
  end

  // ------------------------------------------------------ squares and sum
  logic [NumLanes-1:0][2*CompWidth-1:0] sq_q;
  comp_t                                sq_comp_q;
  logic                                 sq_valid_q;
  logic [SumWidth-1:0]                  sum_q;
  comp_t                                sum_comp_q;
  logic                                 sum_valid_q;
  logic [SumWidth-1:0]                  sum_d;
  comp_t                                sum_comp_d;

  always_comb begin
    sum_d = '0;
    for (int l = 0; l < NumLanes; l++) begin
      sum_d = sum_d + SumWidth'(sq_q[l]);
    end
    sum_comp_d      = sq_comp_q;
    sum_comp_d.zero = (sum_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_valid_q <= 1'b0;
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
    end else if (en) begin
      dec_valid_q <= s_axis_tvalid;
      sq_valid_q  <= dec_valid_q;
      sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dec_q <= dec_d;
      for (int l = 0; l < NumLanes; l++) begin
        sq_q[l] <= dec_q.abs_v[l] * dec_q.abs_v[l];
      end
      sq_comp_q  <= dec_q;
      sum_q      <= sum_d;
      sum_comp_q <= sum_comp_d;
    end
  end

  // ---------------------------------------------------- square-root chain
  logic  [RootWidth:0]                sq_valid_c;
  logic  [RootWidth:0][SumWidth-1:0]  sq_rad_c;
  logic  [RootWidth:0][RootWidth-1:0] sq_root_c;
  logic  [RootWidth:0][RemWidth-1:0]  sq_rem_c;
  comp_t [RootWidth:0]                sq_comp_c;

  assign sq_valid_c[0] = sum_valid_q;
  assign sq_rad_c[0]   = sum_q;
  assign sq_root_c[0]  = '0;
  assign sq_rem_c[0]   = '0;
  assign sq_comp_c[0]  = sum_comp_q;

  for (genvar k = 0; k < RootWidth; k++) begin : g_sqrt
    oqn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid_c[k]),
      .rad_i   (sq_rad_c[k]),
      .root_i  (sq_root_c[k]),
      .rem_i   (sq_rem_c[k]),
      .comp_i  (sq_comp_c[k]),
      .valid_o (sq_valid_c[k+1]),
      .rad_o   (sq_rad_c[k+1]),
      .root_o  (sq_root_c[k+1]),
      .rem_o   (sq_rem_c[k+1]),
      .comp_o  (sq_comp_c[k+1])
    );
  end

  // --------------------------------------------------------- divider setup
  // Rounded quotient is floor((2*a*2^F + M) / (2*M)). The upper bits of the
  // dividend are already below the divisor, so only F+1 quotient bits remain.
  logic                                 ds_valid_q;
  logic [RootWidth:0]                   ds_div_q;
  logic [NumLanes-1:0][RemWidth-1:0]    ds_rem_q;
  logic [NumLanes-1:0][FRAC_BITS:0]     ds_dsh_q;
  comp_t                                ds_comp_q;
  logic [RootWidth-1:0]                 mag;

  assign mag = sq_root_c[RootWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_valid_q <= 1'b0;
    end else if (en) begin
      ds_valid_q <= sq_valid_c[RootWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_div_q  <= {mag, 1'b0};
      ds_comp_q <= sq_comp_c[RootWidth];
      for (int l = 0; l < NumLanes; l++) begin
        logic [DivWidth-1:0] dvd;
        dvd = DivWidth'({sq_comp_c[RootWidth].abs_v[l], {(FRAC_BITS + 1){1'b0}}})
              + DivWidth'(mag);
        ds_rem_q[l] <= RemWidth'(dvd[DivWidth-1:FRAC_BITS+1]);
        ds_dsh_q[l] <= dvd[FRAC_BITS:0];
      end
    end
  end

  // ---------------------------------------------------------- divider chain
  logic  [DivCells:0]                                dv_valid_c;
  logic  [DivCells:0][RootWidth:0]                   dv_div_c;
  logic  [DivCells:0][NumLanes-1:0][RemWidth-1:0]    dv_rem_c;
  logic  [DivCells:0][NumLanes-1:0][FRAC_BITS:0]     dv_dsh_c;
  logic  [DivCells:0][NumLanes-1:0][FRAC_BITS:0]     dv_quo_c;
  comp_t [DivCells:0]                                dv_comp_c;

  assign dv_valid_c[0] = ds_valid_q;
  assign dv_div_c[0]   = ds_div_q;
  assign dv_rem_c[0]   = ds_rem_q;
  assign dv_dsh_c[0]   = ds_dsh_q;
  assign dv_quo_c[0]   = '0;
  assign dv_comp_c[0]  = ds_comp_q;

  for (genvar k = 0; k < DivCells; k++) begin : g_div
    oqn_div_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid_c[k]),
      .div_i   (dv_div_c[k]),
      .rem_i   (dv_rem_c[k]),
      .dsh_i   (dv_dsh_c[k]),
      .quo_i   (dv_quo_c[k]),
      .comp_i  (dv_comp_c[k]),
      .valid_o (dv_valid_c[k+1]),
      .div_o   (dv_div_c[k+1]),
      .rem_o   (dv_rem_c[k+1]),
      .dsh_o   (dv_dsh_c[k+1]),
      .quo_o   (dv_quo_c[k+1]),
      .comp_o  (dv_comp_c[k+1])
    );
  end

  // ------------------------------------------- saturate, sign and zero case
  logic [63:0] fin_data;
  logic        fin_zero;
  logic        fin_valid;

  assign fin_valid = dv_valid_c[DivCells];
  assign fin_zero  = dv_comp_c[DivCells].zero;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      logic [FRAC_BITS:0] q;
      logic [15:0]        mag16;
      q = dv_quo_c[DivCells][l];
      if (q > SatMax) begin
        q = SatMax;
      end
      mag16 = 16'(q);
      if (fin_zero) begin
        fin_data[16*l +: 16] = '0;
      end else if (dv_comp_c[DivCells].neg[l]) begin
        fin_data[16*l +: 16] = 16'd0 - mag16;
      end else begin
        fin_data[16*l +: 16] = mag16;
      end
    end
  end

  // ------------------------------------------------- output and skid buffer
  logic        out_valid_q;
  logic [63:0] out_data_q, skid_data_q;
  logic        out_zero_q, skid_zero_q;
  logic        out_free;

  assign out_free = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (fin_valid) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_data_q <= skid_data_q;
        out_zero_q <= skid_zero_q;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        out_data_q <= fin_data;
        out_zero_q <= fin_zero;
      end else begin
        skid_data_q <= fin_data;
        skid_zero_q <= fin_zero;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_zero_q;

endmodule

/* rtl/oqn_checker.sv */
// ----------------------------------------------------------------------------
// oqn_checker: port-level checks for the quaternion normalizer
// Watches the result stream for held beats and impossible values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module oqn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A zero-magnitude beat carries all-zero components.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("zero magnitude with nonzero components");

  // Saturation never yields the most negative code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000
      && m_axis_tdata[47:32] != 16'h8000 && m_axis_tdata[63:48] != 16'h8000)
    else $error("component out of saturation range");

endmodule

bind orientation_quaternion_normalizer oqn_checker u_oqn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/oqn_checker.sv */
// ----------------------------------------------------------------------------
// oqn_scoreboard: scoreboard for the orientation quaternion normalizer
// Watches both stream channels, predicts each normalized quaternion from the
// accepted raw words and compares every output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module oqn_scoreboard #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [63:0] s_data_i,   // raw_w, raw_x, raw_y, raw_z
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_data_i,   // quat_w, quat_x, quat_y, quat_z
  input  logic        m_user_i,   // zero_magnitude
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic        zero;
    logic [63:0] quat;
  } quat_beat_t;

  quat_beat_t expected_quats[$];
  int         error_count = 0;

  function automatic int decode_axis(logic [15:0] raw);
    if (raw < 16'h8000) return int'(raw);
    if (raw == 16'h8000) return -32767;
    return int'(raw) - 65536;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] s);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > s) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (s >= res + bit_w) begin
        s = s - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] scale_axis(int c, logic [63:0] mag, bit negate);
    logic [63:0] a, q;
    int r;
    a = (c < 0) ? 64'(-c) : 64'(c);
    q = (2 * (a << FRAC_BITS) + mag) / (2 * mag);
    if (q > 64'((1 << FRAC_BITS) - 1)) q = 64'((1 << FRAC_BITS) - 1);
    r = int'(q);
    if (c < 0) r = -r;
    if (negate) r = -r;
    return r[15:0];
  endfunction

  function automatic quat_beat_t normalize_quat(logic [63:0] raw);
    int c[4];
    logic [63:0] sum, mag;
    quat_beat_t b;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      c[i] = decode_axis(raw[16*i +: 16]);
      sum = sum + 64'(c[i] * c[i]);
    end
    b = '0;
    if (sum == 0) begin
      b.zero = 1'b1;
    end else begin
      mag = floor_root(sum);
      for (int i = 0; i < 4; i++) b.quat[16*i +: 16] = scale_axis(c[i], mag, i == 3);
    end
    return b;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  assign errors_o  = error_count;
  assign pending_o = expected_quats.size();

  always @(posedge clk_i) begin
    quat_beat_t want;
    if (s_valid_i && s_ready_i) expected_quats.push_back(normalize_quat(s_data_i));
    if (m_valid_i && m_ready_i) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("output beat with nothing expected");
      end else begin
        want = expected_quats.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_data_i[16*i +: 16] !== want.quat[16*i +: 16])
            report_mismatch($sformatf("lane %0d got %h want %h", i,
                                      m_data_i[16*i +: 16], want.quat[16*i +: 16]));
        if (m_user_i !== want.zero)
          report_mismatch($sformatf("zero flag got %b want %b", m_user_i, want.zero));
      end
    end
  end

endmodule

/* bench/orientation_quaternion_normalizer_tb.sv */
// ----------------------------------------------------------------------------
// orientation_quaternion_normalizer_tb: top of the normalizer testbench
// Drives directed corner samples and then random ones with random gaps and
// output stalls; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module orientation_quaternion_normalizer_tb;

  localparam int NumRandom = 1330;
  // Pipeline depth at the default fraction width, plus margin for the drain.
  localparam int DrainCycles = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // raw_w, raw_x, raw_y, raw_z
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // quat_w, quat_x, quat_y, quat_z
  logic        m_axis_tuser;   // zero_magnitude
  int          errors;
  int          pending;
  bit          calm;           // while set, neither side idles

  orientation_quaternion_normalizer i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  oqn_scoreboard i_checker (
    .clk_i, .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .m_valid_i(m_axis_tvalid),
    .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_user_i(m_axis_tuser), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls about 7 beats in a hundred, except in calm stretches.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 7);
  end

  // A word drawn mostly from interesting corners, otherwise fully random.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'hFFFF;
      4: return 16'h8001;
      5: return 16'(($urandom_range(1) != 0) ? $urandom_range(3) : -$urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one sample beat, holding valid until it is accepted.
  task automatic send_sample(logic [63:0] raw);
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] directed[$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero sample, single axes at both extremes, the 0x8000 word,
    // all lanes full scale, and tiny vectors where rounding and saturation bite.
    directed = '{64'h0, 64'h0000_0000_0000_7FFF, 64'h0000_0000_0000_8000,
                 64'h0000_0000_7FFF_0000, 64'h0000_8001_0000_0000,
                 64'h7FFF_0000_0000_0000, 64'h8000_0000_0000_0000,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h0001_0001_0001_0001,
                 64'h0000_0000_0001_0001, 64'h0001_0001_0001_0000,
                 64'h0002_0001_0000_0001, 64'hFFFF_0001_FFFF_0001,
                 64'h0003_0004_0000_0000, 64'h5555_AAAA_5555_AAAA,
                 64'hAAAA_5555_AAAA_5555, 64'h0000_FFFF_0000_0000};
    foreach (directed[i]) send_sample(directed[i]);

    for (int n = 0; n < NumRandom; n++) begin
      calm <= (n >= 400 && n < 600);
      send_sample({pick_word(), pick_word(), pick_word(), pick_word()});
    end
    s_axis_tvalid <= 1'b0;
    calm <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("** orientation_quaternion_normalizer: PASSED **");
    end else begin
      $display("** orientation_quaternion_normalizer: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** orientation_quaternion_normalizer: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
rtl/oqn_pkg.sv
rtl/oqn_sqrt_cell.sv
rtl/oqn_div_cell.sv
rtl/orientation_quaternion_normalizer.sv
rtl/oqn_checker.sv
bench/oqn_checker.sv
bench/orientation_quaternion_normalizer_tb.sv
